FILE: src/prld_pkg.sv
`default_nettype none
package prld_pkg;
    localparam int STORE_LAST_INDEX = 255;
    localparam int STORE_DEPTH = STORE_LAST_INDEX + 1;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int WIW = $clog2(STORE_DEPTH + 1);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [2:0] OUT_NONE    = 3'd0;
    localparam logic [2:0] OUT_VALID   = 3'd1;
    localparam logic [2:0] OUT_NO_END  = 3'd2;
    localparam logic [2:0] OUT_SHORT   = 3'd3;
    localparam logic [2:0] OUT_TIMEOUT = 3'd4;

    localparam logic [2:0] REG_RUN_LENGTH   = 3'd0;
    localparam logic [2:0] REG_DELTA_WINDOW = 3'd1;
    localparam logic [2:0] REG_MIN_WIDTH    = 3'd2;
    localparam logic [2:0] REG_LONG_IDLE    = 3'd3;
    localparam logic [2:0] REG_IDLE_MATCH   = 3'd4;
    localparam logic [2:0] REG_REPEAT_LIMIT = 3'd5;
    localparam logic [2:0] REG_WAKE_IDLE    = 3'd6;
    localparam logic [2:0] REG_TIMEOUT      = 3'd7;

    typedef struct packed {
        logic [7:0]  run_length;
        logic [15:0] delta_window;
        logic [16:0] min_width;
        logic [31:0] long_idle_us;
        logic [31:0] idle_match_us;
        logic [7:0]  idle_repeat_limit;
        logic [31:0] wake_idle_us;
        logic [30:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [16:0] width;
        logic [31:0] idle_us;
        logic [31:0] now_us;
        logic [31:0] now_ms;
    } t_item;
endpackage
`default_nettype wire

FILE: src/prld_front.sv
`default_nettype none
module prld_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [1:0]     i_opcode,
    input  wire logic [15:0]    i_capture_value,
    input  wire logic [31:0]    i_idle_us,
    input  wire logic [31:0]    i_now_us,
    input  wire logic [31:0]    i_now_ms,
    output logic                o_q_valid,
    output prld_pkg::t_item     o_q_item,
    input  wire logic           i_q_pop
);
    import prld_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].opcode  <= i_opcode;
            r_q[r_wp].width   <= {1'b0, i_capture_value} + 17'd1;
            r_q[r_wp].idle_us <= i_idle_us;
            r_q[r_wp].now_us  <= i_now_us;
            r_q[r_wp].now_ms  <= i_now_ms;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

FILE: src/prld_back.sv
`default_nettype none
module prld_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire prld_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    input  wire prld_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic                o_capture_done,
    output logic [2:0]          o_outcome,
    output logic [31:0]         o_latency_us,
    output logic                o_sleep_flag,
    output logic                o_armed
);
    import prld_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_EVAL} t_state;

    t_state      r_state;
    logic [16:0] r_mem [STORE_DEPTH];
    logic [16:0] r_rd;
    logic [WIW-1:0] r_wi;
    logic        r_armed;
    logic [16:0] r_prev;
    logic [7:0]  r_run;
    logic [31:0] r_end;
    logic [31:0] r_start;
    logic [31:0] r_iprev;
    logic [7:0]  r_irep;
    logic        r_sleep;
    logic [7:0]  r_cnt;
    logic [AW-1:0] r_ra;
    logic [31:0] r_sum;
    logic        r_rdv;
    logic        r_summing;

    t_item       w_it;
    logic        w_take;
    logic        w_edge_ok;
    logic [WIW-1:0] w_wi_inc;
    logic        w_ovf;
    logic signed [17:0] w_delta;
    logic [7:0]  w_run;
    logic        w_runhit;
    logic [31:0] w_gapd;
    logic [7:0]  w_irep;
    logic        w_sleep;
    logic [31:0] w_age;
    logic        w_tmo;

    assign w_it  = i_q_item;
    assign w_take = (r_state == S_IDLE) && i_q_valid && !(o_valid && i_stall);
    assign o_q_pop = w_take;
    assign w_edge_ok = r_armed && (w_it.width > i_cfg.min_width);
    assign w_wi_inc = r_wi + 1'b1;
    assign w_ovf = (w_wi_inc > WIW'(STORE_LAST_INDEX));
    assign w_delta = $signed({1'b0, w_it.width}) - $signed({1'b0, r_prev});
    assign w_run = (w_delta < $signed({2'b0, i_cfg.delta_window}))
                   ? ((r_run == 8'hFF) ? r_run : r_run + 8'd1) : 8'd0;
    assign w_runhit = (w_run >= i_cfg.run_length);
    assign w_gapd = (r_iprev >= w_it.idle_us) ? r_iprev - w_it.idle_us
                                              : w_it.idle_us - r_iprev;
    assign w_age = w_it.now_ms - r_start;
    assign w_tmo = r_armed && !w_age[31] && (w_age > {1'b0, i_cfg.timeout_ms});

    always_comb begin
        w_irep  = r_irep;
        w_sleep = r_sleep;
        if (w_it.idle_us > i_cfg.long_idle_us) begin
            if (w_gapd < i_cfg.idle_match_us)
                w_irep = (r_irep == 8'hFF) ? r_irep : r_irep + 8'd1;
            else
                w_irep = 8'd0;
            if (w_irep > i_cfg.idle_repeat_limit) w_sleep = 1'b1;
        end
        if (w_it.idle_us < i_cfg.wake_idle_us && w_sleep) begin
            w_irep  = 8'd0;
            w_sleep = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_it.opcode == OP_EDGE && w_edge_ok)
            r_mem[r_wi[AW-1:0]] <= w_it.width;
        r_rd <= r_mem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wi <= '0; r_armed <= 1'b0; r_prev <= '0; r_run <= '0;
            r_end <= '0; r_start <= '0; r_iprev <= '0; r_irep <= '0;
            r_sleep <= 1'b0; o_valid <= 1'b0; r_cnt <= '0; r_ra <= '0;
            r_sum <= '0; r_rdv <= 1'b0; r_summing <= 1'b0;
            o_capture_done <= 1'b0; o_outcome <= OUT_NONE; o_latency_us <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (w_it.opcode)
                            OP_START: begin
                                r_wi <= '0; r_prev <= '0; r_run <= '0;
                                r_end <= '0; r_iprev <= '0; r_irep <= '0;
                                r_armed <= 1'b1; r_start <= w_it.now_ms;
                                o_capture_done <= 1'b0;
                                o_outcome      <= OUT_NONE;
                                o_latency_us   <= '0;
                                o_armed <= 1'b1; o_sleep_flag <= r_sleep;
                                o_valid <= 1'b1;
                            end
                            OP_EDGE: begin
                                r_irep <= w_irep; r_sleep <= w_sleep;
                                o_sleep_flag <= w_sleep;
                                o_outcome    <= OUT_NONE;
                                o_latency_us <= '0;
                                if (w_it.idle_us > i_cfg.long_idle_us)
                                    r_iprev <= w_it.idle_us;
                                if (w_edge_ok) begin
                                    r_wi   <= w_ovf ? '0 : w_wi_inc;
                                    r_run  <= w_run;
                                    r_prev <= w_it.width;
                                    if (w_runhit) r_end <= w_it.now_us;
                                end
                                if (w_edge_ok && (w_ovf || w_runhit)) begin
                                    r_armed <= 1'b0;
                                    o_armed <= 1'b0;
                                    o_valid <= 1'b0;
                                    o_capture_done <= 1'b1;
                                    r_sum <= '0;
                                    r_cnt <= i_cfg.run_length;
                                    r_ra  <= r_wi[AW-1:0];
                                    r_rdv <= 1'b0;
                                    r_summing <= !w_ovf &&
                                        (w_wi_inc > WIW'(i_cfg.run_length));
                                    r_state <= S_SUM;
                                end else begin
                                    o_armed <= r_armed;
                                    o_valid <= 1'b1;
                                    o_capture_done <= 1'b0;
                                end
                            end
                            OP_CHECK: begin
                                o_sleep_flag <= r_sleep;
                                o_latency_us <= '0;
                                o_valid <= 1'b1;
                                if (w_tmo) begin
                                    r_wi <= '0; r_prev <= '0; r_run <= '0;
                                    r_end <= '0; r_start <= '0; r_iprev <= '0;
                                    r_irep <= '0; r_armed <= 1'b0;
                                    o_armed <= 1'b0;
                                    o_capture_done <= 1'b1;
                                    o_outcome <= OUT_TIMEOUT;
                                end else begin
                                    o_armed <= r_armed;
                                    o_capture_done <= 1'b0;
                                    o_outcome <= OUT_NONE;
                                end
                            end
                            default: begin
                                o_capture_done <= 1'b0;
                                o_outcome      <= OUT_NONE;
                                o_latency_us   <= '0;
                                o_armed <= r_armed; o_sleep_flag <= r_sleep;
                                o_valid <= 1'b1;
                            end
                        endcase
                    end else if (o_valid && !i_stall) begin
                        o_valid <= 1'b0;
                    end
                end
                S_SUM: begin
                    if (r_rdv) r_sum <= r_sum + {15'd0, r_rd};
                    if (!r_summing || r_cnt == 8'd0) begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) r_state <= S_EVAL;
                    end else begin
                        r_rdv <= 1'b1;
                        r_ra  <= r_ra - 1'b1;
                        r_cnt <= r_cnt - 8'd1;
                    end
                end
                S_EVAL: begin
                    if (r_end == 32'd0) begin
                        o_outcome <= OUT_NO_END;
                    end else if (r_end > r_sum) begin
                        o_outcome <= OUT_VALID;
                        o_latency_us <= r_end - r_sum;
                    end else begin
                        o_outcome <= OUT_SHORT;
                    end
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/pulse_run_latency_detector.sv
`default_nettype none
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_stall  | opcode, capture_value, idle_us, now_us, now_ms
// out     | output    | o_valid / i_stall  | capture_done, outcome, latency_us, sleep_flag, armed
// cfg     | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
// Every item passes from its input transaction through a two-entry queue
// and the back end to its output transaction. A completing edge that sums
// widths first reads one stored width per cycle from the single read port;
// a completing edge that needs no sum reads no widths.
// Synchronous active-low reset clears control; the width store is not cleared.
// Output stall holds the result register and backs up into the queue.
module pulse_run_latency_detector (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_capture_value,
    input  wire logic [31:0] i_idle_us,
    input  wire logic [31:0] i_now_us,
    input  wire logic [31:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_capture_done,
    output logic [2:0]       o_outcome,
    output logic [31:0]      o_latency_us,
    output logic             o_sleep_flag,
    output logic             o_armed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import prld_pkg::*;

    t_cfg   r_cfg;
    logic   w_qv, w_pop;
    t_item  w_qi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_length        <= 8'd8;
            r_cfg.delta_window      <= 16'd50;
            r_cfg.min_width         <= 17'd2;
            r_cfg.long_idle_us      <= 32'd450000;
            r_cfg.idle_match_us     <= 32'd20000;
            r_cfg.idle_repeat_limit <= 8'd20;
            r_cfg.wake_idle_us      <= 32'd500;
            r_cfg.timeout_ms        <= 31'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RUN_LENGTH:   r_cfg.run_length        <= i_cfg_data[7:0];
                REG_DELTA_WINDOW: r_cfg.delta_window      <= i_cfg_data[15:0];
                REG_MIN_WIDTH:    r_cfg.min_width         <= i_cfg_data[16:0];
                REG_LONG_IDLE:    r_cfg.long_idle_us      <= i_cfg_data;
                REG_IDLE_MATCH:   r_cfg.idle_match_us     <= i_cfg_data;
                REG_REPEAT_LIMIT: r_cfg.idle_repeat_limit <= i_cfg_data[7:0];
                REG_WAKE_IDLE:    r_cfg.wake_idle_us      <= i_cfg_data;
                REG_TIMEOUT:      r_cfg.timeout_ms        <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    prld_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_capture_value(i_capture_value),
        .i_idle_us(i_idle_us), .i_now_us(i_now_us), .i_now_ms(i_now_ms),
        .o_q_valid(w_qv), .o_q_item(w_qi), .i_q_pop(w_pop)
    );

    prld_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_q_valid(w_qv), .i_q_item(w_qi), .o_q_pop(w_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_capture_done(o_capture_done), .o_outcome(o_outcome),
        .o_latency_us(o_latency_us), .o_sleep_flag(o_sleep_flag), .o_armed(o_armed)
    );
endmodule
`default_nettype wire

FILE: tb/tb_prld_checker.sv
`default_nettype none
module tb_prld_checker
    import prld_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_capture_value,
    input  wire logic [31:0] i_idle_us,
    input  wire logic [31:0] i_now_us,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_capture_done,
    input  wire logic [2:0]  i_outcome,
    input  wire logic [31:0] i_latency_us,
    input  wire logic        i_sleep_flag,
    input  wire logic        i_armed,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_done_count,
    output int               o_valid_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        done;
        logic [2:0]  outcome;
        logic [31:0] latency;
        logic        sleep;
        logic        armed;
    } t_status;

    t_cfg        cfg;
    logic [16:0] widths [STORE_DEPTH];
    logic [8:0]  wr_idx;
    logic        armed_q;
    logic [16:0] prev_w;
    logic [7:0]  run_cnt;
    logic [31:0] end_us;
    logic [31:0] start_ms_q;
    logic [31:0] idle_prev;
    logic [7:0]  idle_rep;
    logic        sleep_q;
    t_status     status_q [$];

    task automatic clear_capture();
        for (int i = 0; i < STORE_DEPTH; i++) widths[i] = '0;
        wr_idx = '0;
        armed_q = 1'b0;
        prev_w = '0;
        run_cnt = '0;
        end_us = '0;
        start_ms_q = '0;
        idle_prev = '0;
        idle_rep = '0;
    endtask

    task automatic track_idle(input logic [31:0] gap);
        logic [31:0] d;
        if (gap > cfg.long_idle_us) begin
            d = (idle_prev >= gap) ? idle_prev - gap : gap - idle_prev;
            if (d < cfg.idle_match_us) begin
                if (idle_rep != 8'hff) idle_rep++;
            end else begin
                idle_rep = '0;
            end
            if (idle_rep > cfg.idle_repeat_limit) sleep_q = 1'b1;
            idle_prev = gap;
        end
        if (gap < cfg.wake_idle_us && sleep_q) begin
            idle_rep = '0;
            sleep_q = 1'b0;
        end
    endtask

    function automatic logic [2:0] score_latency(output logic [31:0] lat);
        logic [31:0] sum;
        sum = '0;
        lat = '0;
        if (end_us == 0) return OUT_NO_END;
        if (wr_idx > {1'b0, cfg.run_length})
            for (int i = 0; i < cfg.run_length; i++)
                sum += 32'(widths[(wr_idx - 1 - i) % STORE_DEPTH]);
        if (end_us > sum) begin
            lat = end_us - sum;
            return OUT_VALID;
        end
        return OUT_SHORT;
    endfunction

    task automatic predict_status(input logic [1:0] op, input logic [15:0] cap,
                                  input logic [31:0] gap, input logic [31:0] nus,
                                  input logic [31:0] nms);
        t_status     s;
        logic [16:0] w;
        logic        fin;
        logic signed [31:0] dlt;
        logic [31:0] age;
        s = '0;
        if (op == OP_START) begin
            clear_capture();
            armed_q = 1'b1;
            start_ms_q = nms;
        end else if (op == OP_EDGE) begin
            w = {1'b0, cap} + 17'd1;
            if (armed_q && w > cfg.min_width) begin
                fin = 1'b0;
                widths[wr_idx % STORE_DEPTH] = w;
                wr_idx++;
                if (wr_idx > STORE_LAST_INDEX) begin
                    wr_idx = '0;
                    armed_q = 1'b0;
                    fin = 1'b1;
                end
                dlt = $signed({15'd0, w}) - $signed({15'd0, prev_w});
                if (dlt < $signed({16'd0, cfg.delta_window})) begin
                    if (run_cnt != 8'hff) run_cnt++;
                end else begin
                    run_cnt = '0;
                end
                if (run_cnt >= cfg.run_length) begin
                    armed_q = 1'b0;
                    end_us = nus;
                    fin = 1'b1;
                end
                prev_w = w;
                if (fin) begin
                    s.done = 1'b1;
                    s.outcome = score_latency(s.latency);
                end
            end
            track_idle(gap);
        end else if (op == OP_CHECK) begin
            if (armed_q) begin
                age = nms - start_ms_q;
                if (!age[31] && age > {1'b0, cfg.timeout_ms}) begin
                    clear_capture();
                    s.done = 1'b1;
                    s.outcome = OUT_TIMEOUT;
                end
            end
        end
        s.sleep = sleep_q;
        s.armed = armed_q;
        status_q.push_back(s);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_done_count = 0;
        o_valid_count = 0;
        sleep_q = 1'b0;
        cfg = '{8'd8, 16'd50, 17'd2, 32'd450000, 32'd20000, 8'd20, 32'd500, 31'd1000};
        clear_capture();
    end

    always @(posedge i_clk) begin
        t_status w;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RUN_LENGTH:   cfg.run_length = i_cfg_data[7:0];
                    REG_DELTA_WINDOW: cfg.delta_window = i_cfg_data[15:0];
                    REG_MIN_WIDTH:    cfg.min_width = i_cfg_data[16:0];
                    REG_LONG_IDLE:    cfg.long_idle_us = i_cfg_data;
                    REG_IDLE_MATCH:   cfg.idle_match_us = i_cfg_data;
                    REG_REPEAT_LIMIT: cfg.idle_repeat_limit = i_cfg_data[7:0];
                    REG_WAKE_IDLE:    cfg.wake_idle_us = i_cfg_data;
                    REG_TIMEOUT:      cfg.timeout_ms = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    report("unexpected transaction", 0, 0);
                end else begin
                    w = status_q.pop_front();
                    if (i_capture_done != w.done) report("capture_done", i_capture_done, w.done);
                    if (i_outcome != w.outcome) report("outcome", i_outcome, w.outcome);
                    if (i_latency_us != w.latency) report("latency_us", i_latency_us, w.latency);
                    if (i_sleep_flag != w.sleep) report("sleep_flag", i_sleep_flag, w.sleep);
                    if (i_armed != w.armed) report("armed", i_armed, w.armed);
                    if (w.done) o_done_count++;
                    if (w.outcome == OUT_VALID) o_valid_count++;
                end
            end
            if (i_valid && !i_in_stall)
                predict_status(i_opcode, i_capture_value, i_idle_us, i_now_us, i_now_ms);
            o_pending = status_q.size();
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb_pulse_run_latency_detector.sv
`default_nettype none
module tb_pulse_run_latency_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import prld_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [15:0] cap_val = '0;
    logic [31:0] idle_us = '0;
    logic [31:0] now_us = '0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cap_done;
    logic [2:0]  outcome;
    logic [31:0] latency;
    logic        sleep_flag;
    logic        armed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          done_count;
    int          valid_count;
    int          sent;
    logic [31:0] ms_clock;
    logic [31:0] us_clock;
    logic        stall_mode;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pulse_run_latency_detector dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(opcode), .i_capture_value(cap_val), .i_idle_us(idle_us),
        .i_now_us(now_us), .i_now_ms(now_ms), .o_valid(out_valid), .i_stall(out_stall),
        .o_capture_done(cap_done), .o_outcome(outcome), .o_latency_us(latency),
        .o_sleep_flag(sleep_flag), .o_armed(armed), .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tb_prld_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_capture_value(cap_val), .i_idle_us(idle_us),
        .i_now_us(now_us), .i_now_ms(now_ms), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_capture_done(cap_done), .i_outcome(outcome),
        .i_latency_us(latency), .i_sleep_flag(sleep_flag), .i_armed(armed),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending),
        .o_done_count(done_count), .o_valid_count(valid_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) begin
        if (!stall_mode) out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(0, 99) < 30);
    end

    task automatic send(input logic [1:0] op, input logic [15:0] cv, input logic [31:0] gap,
                        input logic [31:0] nus, input logic [31:0] nms);
        int g;
        g = stall_mode ? pick_gap() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        cap_val <= cv;
        idle_us <= gap;
        now_us <= nus;
        now_ms <= nms;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic write_regs(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= v[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic edge_rand(input logic [15:0] base, input int spread);
        logic [31:0] gap;
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) gap = $urandom_range(20, 200);
        else if (r < 8) gap = 32'd450000 + $urandom_range(1, 30000);
        else gap = $urandom();
        us_clock += $urandom_range(0, 300);
        send(OP_EDGE, 16'(base + $urandom_range(0, spread)), gap,
             ($urandom_range(0, 40) == 0) ? 32'd0 : us_clock, ms_clock);
    endtask

    initial begin
        logic [31:0] vals [8];
        sent = 0;
        stall_mode = 1'b0;
        ms_clock = 32'd1000;
        us_clock = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send(OP_EDGE, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send(OP_CHECK, 0, 0, 0, 32'd5);
        send(2'd3, 16'h1234, 32'h5555aaaa, 32'haaaa5555, 32'h1);
        send(OP_START, 0, 0, 0, 32'd100);
        send(OP_EDGE, 16'd1, 32'd100, 32'd10, 32'd100);
        for (int i = 0; i < 9; i++) send(OP_EDGE, 16'd20, 32'd100, 32'd5000 + i, 32'd100);
        send(OP_START, 0, 0, 0, 32'd100);
        for (int i = 0; i < 9; i++) send(OP_EDGE, 16'd20, 32'd100, 32'd0, 32'd100);
        send(OP_START, 0, 0, 0, 32'd100);
        for (int i = 0; i < 9; i++) send(OP_EDGE, 16'd1000, 32'd100, 32'd50, 32'd100);
        send(OP_CHECK, 0, 0, 0, 32'd50);
        send(OP_CHECK, 0, 0, 0, 32'd1101);
        drain();

        vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'hffffffff, 32'd0, 32'hffffffff, 32'd0};
        write_regs(vals);
        send(OP_START, 0, 0, 0, 32'd0);
        send(OP_EDGE, 16'd0, 32'd1, 32'd3, 32'd0);
        send(OP_EDGE, 16'd0, 32'd1, 32'd3, 32'd0);
        send(OP_CHECK, 0, 0, 0, 32'd1);
        drain();

        vals = '{32'd255, 32'd65535, 32'd0, 32'd0, 32'hffffffff, 32'd254, 32'd0, 32'h7fffffff};
        write_regs(vals);
        send(OP_START, 0, 0, 0, 32'd0);
        for (int i = 0; i < 256; i++) send(OP_EDGE, 16'($urandom()), 32'd1, $urandom(), 32'd0);
        drain();
        for (int i = 0; i < 8; i++) vals[i] = 32'h1ffff;
        write_regs(vals);
        drain();

        stall_mode = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            vals[0] = (ph == 0) ? 32'd1 : $urandom_range(2, 12);
            vals[1] = (ph == 1) ? 32'd0 : $urandom_range(10, 300);
            vals[2] = (ph == 2) ? 32'd65536 : $urandom_range(0, 40);
            vals[3] = 32'd450000;
            vals[4] = $urandom_range(5000, 40000);
            vals[5] = $urandom_range(0, 6);
            vals[6] = $urandom_range(0, 1000);
            vals[7] = $urandom_range(0, 3000);
            write_regs(vals);
            while (sent < 330 + (ph + 1) * 230) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    logic [15:0] base;
                    base = 16'($urandom_range(0, 600));
                    ms_clock += $urandom_range(0, 50);
                    us_clock = 0;
                    send(OP_START, 0, 0, 0, ms_clock);
                    repeat ($urandom_range(1, 20)) edge_rand(base, $urandom_range(0, 60));
                end else if (r < 85) begin
                    ms_clock += ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4000);
                    send(OP_CHECK, 0, 0, 0, ms_clock);
                end else begin
                    send(2'($urandom_range(0, 3)), 16'($urandom()), $urandom(),
                         $urandom(), $urandom());
                end
            end
            drain();
        end

        $display("covered %0d items, %0d completed captures, %0d with valid latency",
                 sent, done_count, valid_count);
        if (errors == 0) $display("pulse_run_latency_detector test passed");
        else $display("pulse_run_latency_detector test failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("pulse_run_latency_detector test failed");
        $finish;
    end
endmodule
`default_nettype wire
